>>> hw/rtl/prbs_pkg.sv
// Package for the per-bank refresh scheduler: codes, widths, reset values
// and the bank pick / saturating add helpers. No dependencies.
package prbs_pkg;

    localparam int NUM_BANKS = 16;
    localparam int BANK_W    = $clog2(NUM_BANKS);
    localparam int TIME_W    = 32;
    localparam int INTV_W    = 20;
    localparam int LIM_W     = 8;
    localparam int FLEX_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0]    NEVER_TIME = '1;
    localparam logic [NUM_BANKS-1:0] BANK_ALL   = '1;

    localparam logic [INTV_W-1:0] RST_INTERVAL = INTV_W'(3900);
    localparam logic [INTV_W-1:0] RST_FIRST    = INTV_W'(3900);
    localparam logic [LIM_W-1:0]  RST_MAX_POST = LIM_W'(128);
    localparam logic [LIM_W-1:0]  RST_MAX_PULL = LIM_W'(128);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFRESH_INTERVAL = 2'd0,
        CFG_FIRST_TRIGGER    = 2'd1,
        CFG_MAX_POSTPONED    = 2'd2,
        CFG_MAX_PULLED_IN    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_EVALUATE = 1'b0,
        OP_REPORT   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ISSUED_OTHER    = 3'd0,
        ISSUED_REFPB    = 3'd1,
        ISSUED_REFAB    = 3'd2,
        ISSUED_PD_ENTER = 3'd3,
        ISSUED_SR_ENTER = 3'd4,
        ISSUED_PD_EXIT  = 3'd5
    } issued_t;

    typedef enum logic [1:0] {
        NCMD_NOP   = 2'd0,
        NCMD_PREPB = 2'd1,
        NCMD_REFPB = 2'd2
    } ncmd_t;

    typedef struct packed {
        logic              found;
        logic [BANK_W-1:0] idx;
    } bank_pick_t;

    function automatic bank_pick_t lowest_bank(logic [NUM_BANKS-1:0] m);
        bank_pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = NUM_BANKS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                p.found = 1'b1;
                p.idx   = BANK_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, NEVER_TIME}) ? NEVER_TIME : s[TIME_W-1:0];
    endfunction

endpackage

>>> hw/rtl/per_bank_refresh_scheduler_top.sv
// Per-bank refresh scheduler top level: input register, scheduling logic,
// state and result register. Depends on prbs_pkg.
// Each item passes the input register, then the result register; one item is
// taken every cycle unless out_ready stalls. The scheduling decision and state
// update are one pass of logic between the registers, so an item sees the
// state left by the one before it. Configuration writes take effect at once;
// the user makes them only while no item is in flight (block does not check).
module per_bank_refresh_scheduler_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [prbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prbs_pkg::INTV_W-1:0]   cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [31:0]                   now,
    input  logic [15:0]                   bank_idle,
    input  logic [15:0]                   bank_open,
    input  logic [2:0]                    issued_cmd,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    next_cmd,
    output logic [3:0]                    target_bank,
    output logic                          block_bank,
    output logic                          wake_request,
    output logic [31:0]                   trigger_time
);
    import prbs_pkg::*;

    // configuration
    logic [INTV_W-1:0] interval_reg;
    logic [LIM_W-1:0]  max_post_reg;
    logic [LIM_W-1:0]  max_pull_reg;

    // scheduler state
    logic [TIME_W-1:0]    nt_reg, nt_next;
    logic                 asleep_reg, asleep_next;
    logic                 pim_reg, pim_next;
    logic [FLEX_W-1:0]    flex_reg, flex_next;
    logic                 hold_reg, hold_next;
    logic [NUM_BANKS-1:0] rem_reg, rem_next;
    logic [BANK_W-1:0]    chosen_reg, chosen_next;

    // input register
    logic                 s1_vld_reg;
    logic                 op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [NUM_BANKS-1:0] idle_reg;
    logic [NUM_BANKS-1:0] open_reg;
    logic [2:0]           icmd_reg;

    // result register
    logic                 out_vld_reg;
    logic [1:0]           ncmd_reg, ncmd_next;
    logic [BANK_W-1:0]    tbank_reg;
    logic                 blk_reg, blk_next;
    logic                 wake_reg, wake_next;
    logic [TIME_W-1:0]    ttime_reg;

    logic out_adv;
    logic s1_adv;

    logic [TIME_W-1:0]    intv32;
    logic [TIME_W:0]      late_sum;
    logic                 late;
    logic [TIME_W-1:0]    nt_step;
    logic [TIME_W-1:0]    nt_late;
    logic [TIME_W-1:0]    nt_late_step;
    logic                 pim_eff;
    logic                 forced;
    logic [NUM_BANKS-1:0] cand;
    bank_pick_t           pick_rem;
    bank_pick_t           pick_cand;
    bank_pick_t           pick_clr;
    logic [NUM_BANKS-1:0] rem_clr;
    logic [NUM_BANKS-1:0] rem_fix;
    logic [BANK_W-1:0]    sel_bank;
    logic                 busy;
    logic [FLEX_W-1:0]    flex_dec;
    logic [FLEX_W-1:0]    pull_lim;

    assign out_adv  = !out_vld_reg || out_ready;
    assign s1_adv   = s1_vld_reg && out_adv;
    assign in_ready = !s1_vld_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            now_reg  <= now;
            idle_reg <= bank_idle;
            open_reg <= bank_open;
            icmd_reg <= issued_cmd;
        end
        if (s1_adv)
        begin
            ncmd_reg  <= ncmd_next;
            tbank_reg <= chosen_next;
            blk_reg   <= blk_next;
            wake_reg  <= wake_next;
            ttime_reg <= nt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= RST_INTERVAL;
            max_post_reg <= RST_MAX_POST;
            max_pull_reg <= RST_MAX_PULL;
            nt_reg       <= {{(TIME_W-INTV_W){1'b0}}, RST_FIRST};
            asleep_reg   <= 1'b0;
            pim_reg      <= 1'b0;
            flex_reg     <= '0;
            hold_reg     <= 1'b0;
            rem_reg      <= BANK_ALL;
            chosen_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REFRESH_INTERVAL: interval_reg <= cfg_data;
                CFG_FIRST_TRIGGER:    nt_reg <= {{(TIME_W-INTV_W){1'b0}}, cfg_data};
                CFG_MAX_POSTPONED:    max_post_reg <= cfg_data[LIM_W-1:0];
                CFG_MAX_PULLED_IN:    max_pull_reg <= cfg_data[LIM_W-1:0];
                default:              ;
            endcase
        end
        else if (s1_adv)
        begin
            nt_reg     <= nt_next;
            asleep_reg <= asleep_next;
            pim_reg    <= pim_next;
            flex_reg   <= flex_next;
            hold_reg   <= hold_next;
            rem_reg    <= rem_next;
            chosen_reg <= chosen_next;
        end
    end

    // shared terms
    always_comb
    begin
        intv32       = {{(TIME_W-INTV_W){1'b0}}, interval_reg};
        late_sum     = {1'b0, nt_reg} + {1'b0, intv32};
        late         = {1'b0, now_reg} >= late_sum;
        nt_step      = sat_add(nt_reg, intv32);
        nt_late      = late ? nt_step : nt_reg;
        nt_late_step = sat_add(nt_late, intv32);
        pim_eff      = late ? 1'b0 : pim_reg;
        forced       = flex_reg == {1'b0, max_post_reg};
        cand         = rem_reg & idle_reg;
        pick_rem     = lowest_bank(rem_reg);
        pick_cand    = lowest_bank(cand);
        rem_clr      = rem_reg & ~(NUM_BANKS'(1) << chosen_reg);
        rem_fix      = (rem_clr == '0) ? BANK_ALL : rem_clr;
        pick_clr     = lowest_bank(rem_fix);
        flex_dec     = pim_reg ? (flex_reg - FLEX_W'(1)) : flex_reg;
        pull_lim     = FLEX_W'(0) - {1'b0, max_pull_reg};
        if (hold_reg)
        begin
            sel_bank = chosen_reg;
            busy     = 1'b1;
        end
        else if (pick_cand.found)
        begin
            sel_bank = pick_cand.idx;
            busy     = 1'b0;
        end
        else
        begin
            sel_bank = pick_rem.idx;
            busy     = 1'b1;
        end
    end

    always_comb
    begin
        nt_next     = nt_reg;
        asleep_next = asleep_reg;
        pim_next    = pim_reg;
        flex_next   = flex_reg;
        hold_next   = hold_reg;
        rem_next    = rem_reg;
        chosen_next = chosen_reg;
        ncmd_next   = NCMD_NOP;
        blk_next    = 1'b0;
        wake_next   = 1'b0;
        if (op_reg == OP_EVALUATE)
        begin
            if (nt_reg != NEVER_TIME && now_reg >= nt_reg)
            begin
                wake_next = 1'b1;
                if (!asleep_reg)
                begin
                    nt_next  = nt_late;
                    pim_next = pim_eff;
                    if (!pim_eff)
                    begin
                        chosen_next = sel_bank;
                        if (busy && !forced)
                        begin
                            flex_next = flex_reg + FLEX_W'(1);
                            nt_next   = nt_late_step;
                        end
                        else if (open_reg[sel_bank])
                        begin
                            ncmd_next = NCMD_PREPB;
                        end
                        else
                        begin
                            ncmd_next = NCMD_REFPB;
                            if (forced)
                            begin
                                blk_next  = 1'b1;
                                hold_next = 1'b1;
                            end
                        end
                    end
                    else if (!pick_cand.found)
                    begin
                        pim_next = 1'b0;
                        nt_next  = nt_late_step;
                    end
                    else
                    begin
                        chosen_next = pick_cand.idx;
                        ncmd_next   = open_reg[pick_cand.idx] ? NCMD_PREPB : NCMD_REFPB;
                    end
                end
            end
        end
        else
        begin
            case (icmd_reg)
                ISSUED_REFPB:
                begin
                    hold_next   = 1'b0;
                    rem_next    = rem_fix;
                    chosen_next = pick_clr.idx;
                    flex_next   = flex_dec;
                    pim_next    = 1'b1;
                    if (flex_dec == pull_lim)
                    begin
                        pim_next = 1'b0;
                        nt_next  = nt_step;
                    end
                end
                ISSUED_REFAB:
                begin
                    pim_next    = 1'b0;
                    nt_next     = sat_add(now_reg, intv32);
                    asleep_next = 1'b0;
                    rem_next    = BANK_ALL;
                    chosen_next = '0;
                    hold_next   = 1'b0;
                end
                ISSUED_PD_ENTER:
                begin
                    asleep_next = 1'b1;
                end
                ISSUED_SR_ENTER:
                begin
                    asleep_next = 1'b1;
                    nt_next     = NEVER_TIME;
                end
                ISSUED_PD_EXIT:
                begin
                    asleep_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = out_vld_reg;
    assign next_cmd     = ncmd_reg;
    assign target_bank  = tbank_reg;
    assign block_bank   = blk_reg;
    assign wake_request = wake_reg;
    assign trigger_time = ttime_reg;

endmodule

>>> hw/rtl/prbs_checker.sv
// Port-level checker for the per-bank refresh scheduler, bound to the top.
// Depends on prbs_pkg and per_bank_refresh_scheduler_top.
module prbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  next_cmd,
    input logic [3:0]  target_bank,
    input logic        block_bank,
    input logic        wake_request,
    input logic [31:0] trigger_time
);
    import prbs_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_cmd) &&
        $stable(target_bank) && $stable(block_bank) && $stable(wake_request) &&
        $stable(trigger_time))
        else $error("result changed while stalled");

    // a command is only issued once the trigger fired
    a_cmd_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_cmd != NCMD_NOP |-> wake_request)
        else $error("command without wake request");

    // blocking only with a forced refresh
    a_blk_refpb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_bank |-> next_cmd == NCMD_REFPB && wake_request)
        else $error("block without refresh");

    // no undefined command code
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_cmd == NCMD_NOP || next_cmd == NCMD_PREPB ||
        next_cmd == NCMD_REFPB)
        else $error("bad command code");

endmodule

bind per_bank_refresh_scheduler_top prbs_checker u_prbs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_cmd     (next_cmd),
    .target_bank  (target_bank),
    .block_bank   (block_bank),
    .wake_request (wake_request),
    .trigger_time (trigger_time)
);

>>> verif/tb_top.sv
// Testbench for per_bank_refresh_scheduler_top: directed and random refresh traffic,
// checked against a behavioral scheduler model kept in a small scoreboard class.
// Depends on prbs_pkg and the scheduler RTL.
module tb_top;
    import prbs_pkg::*;

    typedef struct {
        ncmd_t       cmd;
        logic [3:0]  bank;
        logic        blk;
        logic        wake;
        logic [31:0] trig;
    } decision_t;

    class refresh_scoreboard;
        bit [19:0]   interval_q;
        bit [19:0]   first_q;
        bit [7:0]    post_lim;
        bit [7:0]    pull_lim;
        bit [31:0]   trig_at;
        bit          asleep;
        bit          pulled_in;
        bit [8:0]    flex;
        bit          hold_sel;
        bit [15:0]   round_mask;
        bit [3:0]    chosen;
        ncmd_t       last_cmd;
        decision_t   pending[$];
        int          mismatches;

        function new();
            interval_q = RST_INTERVAL;
            first_q    = RST_FIRST;
            post_lim   = RST_MAX_POST;
            pull_lim   = RST_MAX_PULL;
            trig_at    = {12'd0, RST_FIRST};
            asleep     = 1'b0;
            pulled_in  = 1'b0;
            flex       = '0;
            hold_sel   = 1'b0;
            round_mask = '1;
            chosen     = '0;
            last_cmd   = NCMD_NOP;
            mismatches = 0;
        endfunction

        function bit [31:0] add_sat(bit [31:0] a, bit [19:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {13'd0, b};
            if (s >= {1'b0, NEVER_TIME})
                return NEVER_TIME;
            return s[31:0];
        endfunction

        function int first_set(bit [15:0] m);
            for (int i = 0; i < 16; i++)
            begin
                if (m[i])
                    return i;
            end
            return -1;
        endfunction

        function void write_reg(cfg_idx_t idx, bit [19:0] v);
            case (idx)
                CFG_REFRESH_INTERVAL: interval_q = v;
                CFG_FIRST_TRIGGER:
                begin
                    first_q = v;
                    trig_at = {12'd0, v};
                end
                CFG_MAX_POSTPONED: post_lim = v[7:0];
                CFG_MAX_PULLED_IN: pull_lim = v[7:0];
                default: ;
            endcase
        endfunction

        function decision_t evaluate(bit [31:0] t, bit [15:0] idle, bit [15:0] opn);
            decision_t d;
            bit [15:0] cand;
            int        b;
            bit        forced;
            bit        busy;
            d.cmd  = NCMD_NOP;
            d.blk  = 1'b0;
            d.wake = 1'b0;
            d.bank = '0;
            d.trig = '0;
            if (trig_at == NEVER_TIME || t < trig_at)
                return d;
            d.wake = 1'b1;
            if (asleep)
                return d;
            if ({1'b0, t} >= {1'b0, trig_at} + {13'd0, interval_q})
            begin
                trig_at   = add_sat(trig_at, interval_q);
                pulled_in = 1'b0;
            end
            cand = round_mask & idle;
            if (!pulled_in)
            begin
                forced = (flex == {1'b0, post_lim});
                busy   = 1'b1;
                if (!hold_sel)
                begin
                    b      = first_set(round_mask);
                    chosen = (b < 0) ? 4'd0 : 4'(b);
                    b      = first_set(cand);
                    if (b >= 0)
                    begin
                        chosen = 4'(b);
                        busy   = 1'b0;
                    end
                end
                if (busy && !forced)
                begin
                    flex    = flex + 9'd1;
                    trig_at = add_sat(trig_at, interval_q);
                    return d;
                end
                if (opn[chosen])
                    d.cmd = NCMD_PREPB;
                else
                begin
                    d.cmd = NCMD_REFPB;
                    if (forced)
                    begin
                        d.blk    = 1'b1;
                        hold_sel = 1'b1;
                    end
                end
                return d;
            end
            b = first_set(cand);
            if (b < 0)
            begin
                pulled_in = 1'b0;
                trig_at   = add_sat(trig_at, interval_q);
                return d;
            end
            chosen = 4'(b);
            if (opn[chosen])
                d.cmd = NCMD_PREPB;
            else
                d.cmd = NCMD_REFPB;
            return d;
        endfunction

        function void apply_report(bit [31:0] t, bit [2:0] c);
            int b;
            case (c)
                ISSUED_REFPB:
                begin
                    hold_sel           = 1'b0;
                    round_mask[chosen] = 1'b0;
                    if (round_mask == '0)
                        round_mask = '1;
                    b      = first_set(round_mask);
                    chosen = (b < 0) ? 4'd0 : 4'(b);
                    if (pulled_in)
                        flex = flex - 9'd1;
                    else
                        pulled_in = 1'b1;
                    if (flex == 9'd0 - {1'b0, pull_lim})
                    begin
                        pulled_in = 1'b0;
                        trig_at   = add_sat(trig_at, interval_q);
                    end
                end
                ISSUED_REFAB:
                begin
                    pulled_in  = 1'b0;
                    trig_at    = add_sat(t, interval_q);
                    asleep     = 1'b0;
                    round_mask = '1;
                    chosen     = '0;
                    hold_sel   = 1'b0;
                end
                ISSUED_PD_ENTER: asleep = 1'b1;
                ISSUED_SR_ENTER:
                begin
                    asleep  = 1'b1;
                    trig_at = NEVER_TIME;
                end
                ISSUED_PD_EXIT: asleep = 1'b0;
                default: ;
            endcase
        endfunction

        function void note_item(op_t o, bit [31:0] t, bit [15:0] idle, bit [15:0] opn,
                                bit [2:0] c);
            decision_t d;
            d.cmd  = NCMD_NOP;
            d.blk  = 1'b0;
            d.wake = 1'b0;
            if (o == OP_EVALUATE)
                d = evaluate(t, idle, opn);
            else
                apply_report(t, c);
            d.bank   = chosen;
            d.trig   = trig_at;
            last_cmd = d.cmd;
            pending.insert(pending.size(), d);
        endfunction

        function void check_decision(logic [1:0] cmd, logic [3:0] bank, logic blk,
                                     logic wake, logic [31:0] trig);
            decision_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: cmd %0d bank %0d trig %h", cmd, bank, trig);
                return;
            end
            e = pending.pop_front();
            if (cmd !== 2'(e.cmd) || bank !== e.bank || blk !== e.blk ||
                wake !== e.wake || trig !== e.trig)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: cmd %0d/%0d bank %0d/%0d blk %0d/%0d wake %0d/%0d trig %h/%h",
                             e.cmd, cmd, e.bank, bank, e.blk, blk, e.wake, wake, e.trig, trig);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [INTV_W-1:0]    cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [31:0] now;
    logic [15:0] bank_idle;
    logic [15:0] bank_open;
    logic [2:0]  issued_cmd;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  next_cmd;
    logic [3:0]  target_bank;
    logic        block_bank;
    logic        wake_request;
    logic [31:0] trigger_time;

    refresh_scoreboard sb = new();

    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    bit          hold_req     = 1'b0;
    int          stall_left   = 0;
    bit [31:0]   time_cursor  = '0;

    per_bank_refresh_scheduler_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .now          (now),
        .bank_idle    (bank_idle),
        .bank_open    (bank_open),
        .issued_cmd   (issued_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_cmd     (next_cmd),
        .target_bank  (target_bank),
        .block_bank   (block_bank),
        .wake_request (wake_request),
        .trigger_time (trigger_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = 80;
            end
            if (stall_left == 0)
                stall_left = pick_gap(recv_idle_on);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_decision(next_cmd, target_bank, block_bank, wake_request, trigger_time);
    end

    task automatic send_item(op_t o, logic [31:0] t, logic [15:0] idle, logic [15:0] opn,
                             logic [2:0] c);
        int n;
        @(negedge clk);
        in_valid   = 1'b1;
        op         = o;
        now        = t;
        bank_idle  = idle;
        bank_open  = opn;
        issued_cmd = c;
        do @(posedge clk); while (!in_ready);
        sb.note_item(o, t, idle, opn, c);
        n = pick_gap(send_idle_on);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [19:0] v);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random();
        int          r;
        int          r2;
        bit [31:0]   iv;
        bit [31:0]   adv;
        bit [31:0]   t;
        bit [15:0]   idle;
        bit [15:0]   opn;
        bit [2:0]    c;
        op_t         o;
        iv   = {12'd0, sb.interval_q};
        r    = $urandom_range(0, 99);
        r2   = $urandom_range(0, 99);
        o    = OP_EVALUATE;
        c    = 3'($urandom_range(0, 7));
        idle = 16'($urandom);
        opn  = 16'($urandom);
        if (r < 45)
            adv = $urandom_range(0, iv / 4);
        else if (r < 90)
            adv = $urandom_range(iv / 2, iv + 1);
        else
            adv = $urandom_range(0, 3 * iv);
        if (time_cursor < 32'hF000_0000)
            time_cursor = time_cursor + adv;
        t = time_cursor;
        r = $urandom_range(0, 99);
        if (sb.last_cmd == NCMD_REFPB && r < 70)
        begin
            o = OP_REPORT;
            c = ISSUED_REFPB;
        end
        else if (sb.last_cmd == NCMD_PREPB && r < 60)
        begin
            idle[sb.chosen] = 1'b1;
            opn[sb.chosen]  = 1'b0;
        end
        else if (r2 < 60)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                idle = '0;
            else if (r < 55)
                idle = 16'd1 << $urandom_range(0, 15);
            else if (r >= 80)
                idle = '1;
            r = $urandom_range(0, 99);
            if (r >= 40 && r < 65)
                opn = '0;
            else if (r >= 65 && r < 80)
                opn = '1;
            if ($urandom_range(0, 99) < 5)
                t = $urandom;
        end
        else
        begin
            o = OP_REPORT;
            r = $urandom_range(0, 99);
            if (r < 45)
                c = ISSUED_REFPB;
            else if (r < 55)
                c = ISSUED_REFAB;
            else if (r < 65)
                c = ISSUED_PD_ENTER;
            else if (r < 70)
                c = ISSUED_SR_ENTER;
            else if (r < 88)
                c = ISSUED_PD_EXIT;
            else if (r < 92)
                c = ISSUED_OTHER;
            else if (r < 96)
                c = 3'd6;
            else
                c = 3'd7;
        end
        send_item(o, t, idle, opn, c);
    endtask

    initial
    begin
        bit [19:0] iv;
        bit [19:0] ft;
        bit [7:0]  pl;
        bit [7:0]  ul;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_REFRESH_INTERVAL;
        cfg_data   = '0;
        in_valid   = 1'b0;
        op         = OP_EVALUATE;
        now        = '0;
        bank_idle  = '0;
        bank_open  = '0;
        issued_cmd = ISSUED_OTHER;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // default registers
        send_item(OP_EVALUATE, 32'd0, 16'hFFFF, 16'h0000, ISSUED_OTHER);
        send_item(OP_EVALUATE, 32'd3900, 16'hFFFF, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd3900, 16'h0000, 16'h0000, ISSUED_REFPB);
        send_item(OP_EVALUATE, 32'd3900, 16'hFFFF, 16'hFFFF, ISSUED_OTHER);
        send_item(OP_EVALUATE, 32'd3901, 16'h0000, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd0, 16'hFFFF, 16'hFFFF, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd0, 16'h0000, 16'h0000, 3'd6);
        send_item(OP_REPORT, 32'd0, 16'h0000, 16'h0000, 3'd7);
        send_item(OP_EVALUATE, 32'd7800, 16'h0000, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd0, 16'h0000, 16'h0000, ISSUED_PD_ENTER);
        send_item(OP_EVALUATE, 32'd12000, 16'hFFFF, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd0, 16'h0000, 16'h0000, ISSUED_PD_EXIT);
        send_item(OP_EVALUATE, 32'd12000, 16'h8000, 16'h8000, ISSUED_OTHER);
        send_item(OP_EVALUATE, 32'd12000, 16'h8000, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd12000, 16'h0000, 16'h0000, ISSUED_REFPB);
        send_item(OP_REPORT, 32'd12000, 16'h0000, 16'h0000, ISSUED_REFPB);
        send_item(OP_REPORT, 32'd0, 16'h0000, 16'h0000, ISSUED_SR_ENTER);
        send_item(OP_EVALUATE, 32'hFFFF_FFFE, 16'hFFFF, 16'h0000, ISSUED_OTHER);
        send_item(OP_REPORT, 32'hFFFF_FFFE, 16'h0000, 16'h0000, ISSUED_REFAB);
        send_item(OP_EVALUATE, 32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF, ISSUED_OTHER);
        send_item(OP_REPORT, 32'd100, 16'h0000, 16'h0000, ISSUED_REFAB);
        send_item(OP_EVALUATE, 32'hFFFF_FFFE, 16'h0001, 16'h0000, ISSUED_OTHER);
        @(negedge clk);
        in_valid = 1'b0;
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            iv = 20'($urandom_range(1, 40));
            ft = 20'($urandom_range(0, 100));
            pl = 8'($urandom_range(0, 4));
            ul = 8'($urandom_range(0, 4));
            send_idle_on = 1'b1;
            recv_idle_on = 1'b1;
            case (ph)
                0:
                begin
                    iv = 20'd1;
                    ft = 20'd0;
                    pl = 8'd0;
                    ul = 8'd0;
                end
                1:
                begin
                    iv = 20'hFFFFF;
                    ft = 20'hFFFFF;
                    pl = 8'hFF;
                    ul = 8'hFF;
                end
                3:
                begin
                    pl = 8'hFF;
                    ul = 8'hFF;
                end
                5: send_idle_on = 1'b0;
                6:
                begin
                    send_idle_on = 1'b0;
                    recv_idle_on = 1'b0;
                end
                default: ;
            endcase
            write_cfg(CFG_REFRESH_INTERVAL, iv);
            write_cfg(CFG_FIRST_TRIGGER, ft);
            write_cfg(CFG_MAX_POSTPONED, {12'($urandom), pl});
            write_cfg(CFG_MAX_PULLED_IN, {12'($urandom), ul});
            time_cursor = '0;
            if (ph == 5)
                hold_req = 1'b1;
            for (int k = 0; k < 115; k++)
                send_random();
            @(negedge clk);
            in_valid = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
